/* rtl/gsts_pkg.sv */
package gsts_pkg;

    localparam int OffsetWidth = 18;
    localparam int OccWidth    = 17;
    localparam int IndexWidth  = 5;
    localparam int StartWidth  = 16;
    localparam int AmpWidth    = 15;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 17;
    localparam int InDataWidth  = 24;
    localparam int OutDataWidth = 24;

    // golden-ratio fractions, scaled by 2^32
    localparam logic [31:0] FracLow  = 32'h61C8_8647;
    localparam logic [31:0] FracHigh = 32'h9E37_79B9;

    localparam logic [IndexWidth-1:0] MaxProbeIndex = 5'd17;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_MEAS  = 1'b1;

    localparam logic [CfgIdxWidth-1:0] CFG_REL_START = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_AMPLITUDE = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_TARGET    = 2'd2;

    typedef logic signed [OffsetWidth-1:0] offset_t;

    typedef struct packed {
        logic [StartWidth-1:0] rel_start;
        logic [AmpWidth-1:0]   amplitude;
        logic [OccWidth-1:0]   target;
        logic [IndexWidth-1:0] last_index;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        offset_t               dac_offset;
        logic                  is_final;
        logic [IndexWidth-1:0] probe_index;
    } result_t;

    // bit length of a 16-bit value
    function automatic logic [IndexWidth-1:0] bit_len16(input logic [15:0] x);
        logic [IndexWidth-1:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) begin
                n = IndexWidth'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

/* rtl/golden_section_threshold_search_unit.sv */
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid / s_tready  s_tuser = action, s_tdata = occupancy
// m_       out  m_tvalid / m_tready  m_tdata = dac_offset, probe_index; m_tlast = is_final
// cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word is accepted per cycle while the output is not stalled. A word's result, if any,
// goes via the input register, update logic and multiplier into the output register.
// The single 19 x 32 bit probe multiply sets the critical path.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled output holds the pipe; the input register drains as soon as the output
// register is free or being taken. cfg_ready is always high.
module golden_section_threshold_search_unit
    import gsts_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [InDataWidth-1:0]  s_tdata,    // [16:0] occupancy
    input  logic                    s_tuser,    // [0] action
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OutDataWidth-1:0] m_tdata,    // [17:0] dac_offset, [22:18] probe_index
    output logic                    m_tlast,    // is_final
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    logic                  in_valid_reg, in_valid_next;
    logic                  in_action_reg;
    logic [OccWidth-1:0]   in_occ_reg;
    logic                  out_valid_reg, out_valid_next;
    offset_t               out_offset_reg;
    logic                  out_final_reg;
    logic [IndexWidth-1:0] out_index_reg;
    logic                  out_free;
    logic                  fire;
    logic                  s_fire;
    cfg_t                  cfg;
    result_t               res;
    logic                  search_active;

    assign cfg_ready = 1'b1;

    gsts_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    gsts_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .action        (in_action_reg),
        .occupancy     (in_occ_reg),
        .cfg           (cfg),
        .res           (res),
        .search_active (search_active)
    );

    assign in_valid_next  = s_fire || (in_valid_reg && !fire);
    // hold the result until taken; load a new one when the core produces it
    assign out_valid_next = (fire && res.valid) || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_action_reg <= s_tuser;
            in_occ_reg    <= s_tdata[OccWidth-1:0];
        end
        if (fire && res.valid) begin
            out_offset_reg <= res.dac_offset;
            out_final_reg  <= res.is_final;
            out_index_reg  <= res.probe_index;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_index_reg, out_offset_reg};
    assign m_tlast  = out_final_reg;

    a_start_gives_probe_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_action_reg == ACT_START |=> m_tvalid && !m_tlast
            && m_tdata[22:18] == '0 && search_active)
        else $error("start word did not open a search with probe zero");

    a_final_ends_search: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.valid && res.is_final |=> !search_active)
        else $error("search still active after final result");

    a_idle_measure_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_action_reg == ACT_MEAS && !search_active |-> !res.valid)
        else $error("measurement while idle produced a result");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[22:18] <= MaxProbeIndex)
        else $error("probe index out of range");

endmodule

/* rtl/gsts_cfg.sv */
module gsts_cfg
    import gsts_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    output cfg_t                    cfg
);

    logic [StartWidth-1:0] rel_start_reg;
    logic [AmpWidth-1:0]   amplitude_reg;
    logic [OccWidth-1:0]   target_reg;
    logic [IndexWidth-1:0] last_index_reg;
    logic [IndexWidth-1:0] last_index_next;

    // last probe index follows amplitude: bit_length(amplitude + 1) + 1
    assign last_index_next = bit_len16(16'(cfg_data[AmpWidth-1:0]) + 16'd1) + 5'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_start_reg  <= '0;
            amplitude_reg  <= 15'd255;
            target_reg     <= 17'd32768;
            last_index_reg <= 5'd10;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_REL_START: rel_start_reg <= cfg_data[StartWidth-1:0];
                CFG_AMPLITUDE: begin
                    amplitude_reg  <= cfg_data[AmpWidth-1:0];
                    last_index_reg <= last_index_next;
                end
                CFG_TARGET:    target_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.rel_start  = rel_start_reg;
    assign cfg.amplitude  = amplitude_reg;
    assign cfg.target     = target_reg;
    assign cfg.last_index = last_index_reg;

endmodule

/* rtl/gsts_probe.sv */
module gsts_probe
    import gsts_pkg::*;
(
    input  offset_t win_low,
    input  offset_t win_high,
    input  logic    sel_high,
    output offset_t probe
);

    logic signed [OffsetWidth:0]   span;
    logic signed [51:0]            span_ext;
    logic signed [51:0]            frac_ext;
    logic signed [51:0]            prod;
    logic signed [OffsetWidth:0]   part;
    logic signed [OffsetWidth:0]   sum;

    assign span     = {win_high[OffsetWidth-1], win_high} - {win_low[OffsetWidth-1], win_low};
    assign span_ext = 52'(span);
    assign frac_ext = {20'd0, (sel_high ? FracHigh : FracLow)};
    assign prod     = span_ext * frac_ext;
    // arithmetic shift by 32 floors toward minus infinity
    assign part     = prod[50:32];
    assign sum      = {win_low[OffsetWidth-1], win_low} + part;
    assign probe    = sum[OffsetWidth-1:0];

endmodule

/* rtl/gsts_core.sv */
module gsts_core
    import gsts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic                action,
    input  logic [OccWidth-1:0] occupancy,
    input  cfg_t                cfg,
    output result_t             res,
    output logic                search_active
);

    offset_t               window_low_reg, window_low_next;
    offset_t               window_high_reg, window_high_next;
    offset_t               probe_low_reg, probe_low_next;
    offset_t               probe_high_reg, probe_high_next;
    logic [OccWidth-1:0]   occ_low_reg, occ_low_next;
    logic [OccWidth-1:0]   occ_high_reg, occ_high_next;
    logic                  probing_high_reg, probing_high_next;
    logic [IndexWidth-1:0] step_count_reg, step_count_next;
    offset_t               last_probe_reg, last_probe_next;
    logic                  active_reg, active_next;

    // update stage before the new probe is placed
    offset_t               pl_upd, ph_upd;
    logic                  need_probe;
    logic                  fin;
    offset_t               final_offset;
    logic                  res_valid;
    logic [IndexWidth-1:0] res_index;
    offset_t               probe_v;

    always_comb begin
        offset_t               start;
        logic [OccWidth-1:0]   lo, hi, dl, dh;
        logic [IndexWidth-1:0] idx;

        window_low_next   = window_low_reg;
        window_high_next  = window_high_reg;
        pl_upd            = probe_low_reg;
        ph_upd            = probe_high_reg;
        occ_low_next      = occ_low_reg;
        occ_high_next     = occ_high_reg;
        probing_high_next = probing_high_reg;
        step_count_next   = step_count_reg;
        active_next       = active_reg;
        need_probe        = 1'b0;
        fin               = 1'b0;
        final_offset      = last_probe_reg;
        res_valid         = 1'b0;
        res_index         = step_count_reg;
        start = {{(OffsetWidth-StartWidth){cfg.rel_start[StartWidth-1]}}, cfg.rel_start};
        idx   = step_count_reg;
        lo    = '0;
        hi    = '0;
        dl    = '0;
        dh    = '0;

        if (fire) begin
            if (action == ACT_START) begin
                window_low_next   = start;
                window_high_next  = start + OffsetWidth'(cfg.amplitude) + 18'sd1;
                occ_low_next      = '0;
                occ_high_next     = '0;
                probing_high_next = 1'b0;
                step_count_next   = '0;
                active_next       = 1'b1;
                need_probe        = 1'b1;
                res_valid         = 1'b1;
                res_index         = '0;
            end else if (active_reg) begin
                res_valid = 1'b1;
                if (idx == '0) begin
                    occ_low_next      = occupancy;
                    probing_high_next = 1'b1;
                end else begin
                    if (probing_high_reg) begin
                        occ_high_next = occupancy;
                    end else begin
                        occ_low_next = occupancy;
                    end
                    lo = occ_low_next;
                    hi = occ_high_next;
                    if (idx >= cfg.last_index) begin
                        dl = (lo > cfg.target) ? lo - cfg.target : cfg.target - lo;
                        dh = (hi > cfg.target) ? hi - cfg.target : cfg.target - hi;
                        if (dl < dh) begin
                            final_offset = probe_low_reg;
                        end else if (dh < dl) begin
                            final_offset = probe_high_reg;
                        end
                        fin         = 1'b1;
                        active_next = 1'b0;
                    end else begin
                        if (lo < hi || lo > cfg.target) begin
                            window_low_next = probe_low_reg;
                        end
                        if (hi > cfg.target) begin
                            window_low_next = probe_high_reg;
                        end
                        if (lo >= hi && hi < cfg.target) begin
                            window_high_next = probe_high_reg;
                        end
                        if (lo < hi || hi > cfg.target) begin
                            pl_upd       = probe_high_reg;
                            occ_low_next = hi;
                        end
                        if (lo >= hi && lo < cfg.target) begin
                            ph_upd            = pl_upd;
                            occ_high_next     = lo;
                            probing_high_next = 1'b0;
                        end else begin
                            probing_high_next = 1'b1;
                        end
                    end
                end
                if (!fin) begin
                    need_probe      = 1'b1;
                    step_count_next = idx + 5'd1;
                    res_index       = idx + 5'd1;
                end else begin
                    res_index = idx;
                end
            end
        end
    end

    gsts_probe u_probe (
        .win_low  (window_low_next),
        .win_high (window_high_next),
        .sel_high (probing_high_next),
        .probe    (probe_v)
    );

    // place the new probe
    always_comb begin
        probe_low_next  = pl_upd;
        probe_high_next = ph_upd;
        last_probe_next = last_probe_reg;
        if (need_probe) begin
            last_probe_next = probe_v;
            if (probing_high_next) begin
                probe_high_next = probe_v;
            end else begin
                probe_low_next = probe_v;
            end
        end
    end

    always_comb begin
        res.valid       = res_valid;
        res.dac_offset  = fin ? final_offset : probe_v;
        res.is_final    = fin;
        res.probe_index = res_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_low_reg   <= '0;
            window_high_reg  <= '0;
            probe_low_reg    <= '0;
            probe_high_reg   <= '0;
            occ_low_reg      <= '0;
            occ_high_reg     <= '0;
            probing_high_reg <= 1'b0;
            step_count_reg   <= '0;
            last_probe_reg   <= '0;
            active_reg       <= 1'b0;
        end else begin
            window_low_reg   <= window_low_next;
            window_high_reg  <= window_high_next;
            probe_low_reg    <= probe_low_next;
            probe_high_reg   <= probe_high_next;
            occ_low_reg      <= occ_low_next;
            occ_high_reg     <= occ_high_next;
            probing_high_reg <= probing_high_next;
            step_count_reg   <= step_count_next;
            last_probe_reg   <= last_probe_next;
            active_reg       <= active_next;
        end
    end

    assign search_active = active_reg;

endmodule

/* bench/threshold_search_checker.sv */
`timescale 1ns / 100ps

module threshold_search_checker
    import gsts_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [InDataWidth-1:0]  s_tdata,    // [16:0] occupancy
    input  logic                    s_tuser,    // [0] action
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OutDataWidth-1:0] m_tdata,    // [17:0] dac_offset, [22:18] probe_index
    input  logic                    m_tlast,    // is_final
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    output int                      mismatches,
    output int                      outstanding
);

    typedef struct {
        offset_t               dac_offset;
        logic                  is_final;
        logic [IndexWidth-1:0] probe_index;
    } probe_word_t;

    probe_word_t probe_words_due[$];

    // shadow of the configuration registers
    logic [StartWidth-1:0] rel_start;
    logic [AmpWidth-1:0]   amplitude;
    logic [OccWidth-1:0]   target;

    // search state
    int                    win_lo;
    int                    win_hi;
    int                    probe_lo;
    int                    probe_hi;
    int                    last_probe;
    logic [OccWidth-1:0]   occ_lo;
    logic [OccWidth-1:0]   occ_hi;
    logic                  on_high_probe;
    logic [IndexWidth-1:0] step;
    logic                  searching;

    // window edge plus floor(width * frac / 2^32), exact toward minus infinity
    function automatic int golden_point(input int lo, input int hi, input logic [31:0] frac);
        longint prod;
        prod = longint'(hi - lo) * longint'({32'h0, frac});
        return lo + int'(prod >>> 32);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic predict_search_step(input logic act, input logic [OccWidth-1:0] occ);
        logic [IndexWidth-1:0] idx;
        int                    last_idx;
        logic [OccWidth-1:0]   lo;
        logic [OccWidth-1:0]   hi;
        logic [OccWidth-1:0]   dist_lo;
        logic [OccWidth-1:0]   dist_hi;
        int                    offset;
        logic                  fin;
        probe_word_t           w;
        fin = 1'b0;
        offset = 0;
        if (act == ACT_START) begin
            win_lo = int'($signed(rel_start));
            win_hi = win_lo + int'(amplitude) + 1;
            occ_lo = '0;
            occ_hi = '0;
            on_high_probe = 1'b0;
            step = '0;
            searching = 1'b1;
            idx = '0;
        end else begin
            // drop measurements that arrive with no search running
            if (!searching) return;
            idx = step;
            last_idx = $clog2(int'(amplitude) + 2) + 1;
            if (idx == '0) begin
                occ_lo = occ;
                on_high_probe = 1'b1;
            end else begin
                if (on_high_probe) begin
                    occ_hi = occ;
                end else begin
                    occ_lo = occ;
                end
                lo = occ_lo;
                hi = occ_hi;
                if (int'(idx) >= last_idx) begin
                    dist_lo = (lo > target) ? lo - target : target - lo;
                    dist_hi = (hi > target) ? hi - target : target - hi;
                    if (dist_lo < dist_hi) begin
                        offset = probe_lo;
                    end else if (dist_hi < dist_lo) begin
                        offset = probe_hi;
                    end else begin
                        offset = last_probe;
                    end
                    fin = 1'b1;
                    searching = 1'b0;
                end else begin
                    if (lo < hi || lo > target) win_lo = probe_lo;
                    if (hi > target) win_lo = probe_hi;
                    if (lo >= hi && hi < target) win_hi = probe_hi;
                    if (lo < hi || hi > target) begin
                        probe_lo = probe_hi;
                        occ_lo = hi;
                    end
                    if (lo >= hi && lo < target) begin
                        probe_hi = probe_lo;
                        occ_hi = lo;
                        on_high_probe = 1'b0;
                    end else begin
                        on_high_probe = 1'b1;
                    end
                end
            end
            if (!fin) idx = idx + 1'b1;
        end
        if (!fin) begin
            offset = golden_point(win_lo, win_hi, on_high_probe ? FracHigh : FracLow);
            if (on_high_probe) begin
                probe_hi = offset;
            end else begin
                probe_lo = offset;
            end
            last_probe = offset;
            step = idx;
        end
        w.dac_offset = offset_t'(offset);
        w.is_final = fin;
        w.probe_index = idx;
        probe_words_due = {probe_words_due, w};
    endtask

    task automatic check_result_word();
        probe_word_t w;
        if (probe_words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word, tdata %h tlast %b", m_tdata, m_tlast));
            return;
        end
        w = probe_words_due.pop_front();
        if (m_tdata[OffsetWidth-1:0] !== w.dac_offset) begin
            report_mismatch($sformatf("dac_offset %0d, expected %0d",
                $signed(m_tdata[OffsetWidth-1:0]), w.dac_offset));
        end
        if (m_tdata[OffsetWidth +: IndexWidth] !== w.probe_index) begin
            report_mismatch($sformatf("probe_index %0d, expected %0d",
                m_tdata[OffsetWidth +: IndexWidth], w.probe_index));
        end
        if (m_tlast !== w.is_final) begin
            report_mismatch($sformatf("is_final %b, expected %b", m_tlast, w.is_final));
        end
        if (m_tdata[OutDataWidth-1:OffsetWidth+IndexWidth] !== '0) begin
            report_mismatch($sformatf("padding bits set, tdata %h", m_tdata));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rel_start = '0;
            amplitude = AmpWidth'(255);
            target = OccWidth'(32768);
            win_lo = 0;
            win_hi = 0;
            probe_lo = 0;
            probe_hi = 0;
            last_probe = 0;
            occ_lo = '0;
            occ_hi = '0;
            on_high_probe = 1'b0;
            step = '0;
            searching = 1'b0;
            probe_words_due.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REL_START: rel_start = cfg_data[StartWidth-1:0];
                    CFG_AMPLITUDE: amplitude = cfg_data[AmpWidth-1:0];
                    CFG_TARGET:    target = cfg_data[OccWidth-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_search_step(s_tuser, s_tdata[OccWidth-1:0]);
            end
            if (m_tvalid && m_tready) begin
                check_result_word();
            end
            outstanding <= probe_words_due.size();
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import gsts_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int PhaseCount    = 9;
    localparam int PhaseItems    = 80;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CfgIdxWidth-1:0]  cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_data  = '0;

    int mismatches;
    int outstanding;

    logic                no_idle        = 1'b0;
    int                  m_hold         = 0;
    int                  stall_len      = 0;
    int                  idle_cycles    = 0;
    int                  items_sent     = 0;
    int                  left_in_search = 0;
    int                  cur_amp        = 255;
    int                  cur_target     = 32768;
    logic [OccWidth-1:0] prev_occ       = '0;

    golden_section_threshold_search_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    threshold_search_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // occupancy near the target, repeated or mirrored for ties, or anywhere
    function automatic logic [OccWidth-1:0] rand_occ();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            v = cur_target + int'($urandom_range(0, 2000)) - 1000;
        end else if (r < 45) begin
            v = int'(prev_occ);
        end else if (r < 55) begin
            v = 2 * cur_target - int'(prev_occ);
        end else if (r < 65) begin
            case ($urandom_range(0, 3))
                0: v = 0;
                1: v = 65536;
                2: v = 131071;
                default: v = cur_target;
            endcase
        end else if (r < 85) begin
            v = int'($urandom_range(0, 65536));
        end else begin
            v = int'($urandom_range(0, 131071));
        end
        if (v < 0) v = 0;
        if (v > 131071) v = 131071;
        prev_occ = v[OccWidth-1:0];
        return prev_occ;
    endfunction

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_hold <= 0;
        end else if (m_hold > 0) begin
            m_tready <= 1'b0;
            m_hold <= m_hold - 1;
        end else begin
            stall_len = pick_gap();
            m_tready <= (stall_len == 0);
            m_hold <= (stall_len > 0) ? stall_len - 1 : 0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WatchdogLimit) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_word(input logic act, input logic [OccWidth-1:0] occ);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= InDataWidth'(occ);
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgDataWidth-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
    endtask

    // hold until every expected word is back, then cover words that give no result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [StartWidth-1:0] st, input logic [AmpWidth-1:0] amp,
                                  input logic [OccWidth-1:0] tgt);
        write_reg(CFG_REL_START, CfgDataWidth'(st));
        write_reg(CFG_AMPLITUDE, CfgDataWidth'(amp));
        write_reg(CFG_TARGET, CfgDataWidth'(tgt));
        cfg_valid <= 1'b0;
        cur_amp = int'(amp);
        cur_target = int'(tgt);
    endtask

    task automatic emit_item();
        int r;
        r = $urandom_range(0, 99);
        if (left_in_search == 0) begin
            if (r < 85) begin
                send_word(ACT_START, rand_occ());
                left_in_search = $clog2(cur_amp + 2) + 2;
                items_sent++;
            end else begin
                // stray measurement, normally ignored
                send_word(ACT_MEAS, rand_occ());
            end
        end else if (r < 3) begin
            // restart in the middle of a search
            send_word(ACT_START, rand_occ());
            left_in_search = $clog2(cur_amp + 2) + 2;
            items_sent++;
        end else begin
            send_word(ACT_MEAS, rand_occ());
            left_in_search--;
            items_sent++;
        end
    endtask

    initial begin
        logic [StartWidth-1:0] st;
        logic [AmpWidth-1:0]   amp;
        logic [OccWidth-1:0]   tgt;
        int                    quota;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: window [0, 256], target 32768
        send_word(ACT_MEAS, OccWidth'(131071));
        send_word(ACT_START, OccWidth'(0));
        send_word(ACT_MEAS, OccWidth'(0));
        send_word(ACT_MEAS, OccWidth'(65536));
        send_word(ACT_MEAS, OccWidth'(131071));
        send_word(ACT_START, OccWidth'(131071));
        send_word(ACT_MEAS, OccWidth'(32768));
        send_word(ACT_MEAS, OccWidth'(32768));
        send_word(ACT_MEAS, OccWidth'(0));
        send_word(ACT_MEAS, OccWidth'(65536));
        send_word(ACT_MEAS, OccWidth'(40000));
        send_word(ACT_MEAS, OccWidth'(20000));
        send_word(ACT_MEAS, OccWidth'(131071));
        send_word(ACT_MEAS, OccWidth'(32768));
        send_word(ACT_MEAS, OccWidth'(32769));
        send_word(ACT_MEAS, OccWidth'(32767));
        send_word(ACT_MEAS, OccWidth'(32768));
        send_word(ACT_MEAS, OccWidth'(1000));
        send_word(ACT_START, OccWidth'(0));
        send_word(ACT_MEAS, OccWidth'(10000));
        send_word(ACT_MEAS, OccWidth'(50000));
        send_word(ACT_MEAS, OccWidth'(30000));
        send_word(ACT_MEAS, OccWidth'(33000));
        send_word(ACT_MEAS, OccWidth'(32000));
        settle();
        // lower the amplitude mid-search so the next measurement is past the last probe index
        write_reg(CFG_AMPLITUDE, CfgDataWidth'(0));
        cfg_valid <= 1'b0;
        cur_amp = 0;
        send_word(ACT_MEAS, OccWidth'(32768));
        settle();

        for (int phase = 0; phase < PhaseCount; phase++) begin
            case (phase)
                0: begin st = 16'h8000; amp = 15'h7FFF; tgt = 17'd0;      end
                1: begin st = 16'h7FFF; amp = 15'h7FFF; tgt = 17'h1FFFF;  end
                2: begin st = 16'h7FFF; amp = 15'd0;    tgt = 17'd65536;  end
                3: begin st = 16'h8000; amp = 15'd0;    tgt = 17'd0;      end
                4: begin st = 16'h0000; amp = 15'd1;    tgt = 17'd32768;  end
                default: begin
                    st = StartWidth'($urandom);
                    amp = ($urandom_range(0, 4) == 0) ? AmpWidth'($urandom)
                                                      : AmpWidth'($urandom_range(0, 600));
                    tgt = ($urandom_range(0, 1) == 0) ? OccWidth'($urandom_range(0, 131071))
                                                      : OccWidth'($urandom_range(16384, 49152));
                end
            endcase
            apply_settings(st, amp, tgt);
            no_idle <= ($urandom_range(0, 3) == 0);
            quota = items_sent + PhaseItems;
            while (items_sent < quota) emit_item();
            settle();
        end

        @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/gsts_pkg.sv
rtl/gsts_cfg.sv
rtl/gsts_probe.sv
rtl/gsts_core.sv
rtl/golden_section_threshold_search_unit.sv
bench/threshold_search_checker.sv
bench/tb_top.sv
